/* design/shcr_pkg.sv */
// ----------------------------------------------------------------------------
// Storage host controller register file: shared definitions
// Request and response payloads, register offsets, fixed words, opcodes
// and the register select codes used between decode and the register file.
// ----------------------------------------------------------------------------
`default_nettype none

package shcr_pkg;

	typedef struct packed {
		logic        kind;
		logic [11:0] offset;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_level;
	} rsp_t;

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	// Fixed identification words.
	localparam logic [31:0] CAP_WORD   = 32'h1107_001F;
	localparam logic [31:0] VER_WORD   = 32'h0000_0300;
	localparam logic [31:0] HWVER_WORD = 32'h4000_0000;
	localparam logic [31:0] CCAP_WORD  = 32'h4000_1F01;
	localparam logic [31:0] CCAP0_WORD = 32'h000F_0300;

	// Host status reads back with this bit always set.
	localparam logic [31:0] HS_READ_FLAG = 32'h0000_0100;

	// Link command opcodes and the power mode attribute id.
	localparam logic [7:0]  OP_SET       = 8'h02;
	localparam logic [7:0]  OP_LINKUP    = 8'h16;
	localparam logic [7:0]  OP_HIB_ENTER = 8'h17;
	localparam logic [7:0]  OP_HIB_EXIT  = 8'h18;
	localparam logic [15:0] PWRMODE_ATTR = 16'h2141;

	// Interrupt status bits.
	localparam logic [31:0] ST_XFER_DONE = 32'h0000_0001;
	localparam logic [31:0] ST_PWR       = 32'h0000_0010;
	localparam logic [31:0] ST_HIB_EXIT  = 32'h0000_0020;
	localparam logic [31:0] ST_HIB_ENTER = 32'h0000_0040;
	localparam logic [31:0] ST_LINKUP    = 32'h0000_0100;
	localparam logic [31:0] ST_TASK_DONE = 32'h0000_0200;
	localparam logic [31:0] ST_CMD_DONE  = 32'h0000_0400;

	// Host status bits.
	localparam logic [3:0] HS_PRESENT  = 4'h1;
	localparam logic [3:0] HS_XFER_RDY = 4'h2;
	localparam logic [3:0] HS_TASK_RDY = 4'h4;
	localparam logic [3:0] HS_CMD_RDY  = 4'h8;

	// Register offsets.
	localparam logic [11:0] OFF_CAP     = 12'h000;
	localparam logic [11:0] OFF_VER     = 12'h008;
	localparam logic [11:0] OFF_IS      = 12'h020;
	localparam logic [11:0] OFF_IE      = 12'h024;
	localparam logic [11:0] OFF_HS      = 12'h030;
	localparam logic [11:0] OFF_CTRL    = 12'h034;
	localparam logic [11:0] OFF_XBASE_L = 12'h050;
	localparam logic [11:0] OFF_XBASE_H = 12'h054;
	localparam logic [11:0] OFF_XDB     = 12'h058;
	localparam logic [11:0] OFF_XCLR    = 12'h05C;
	localparam logic [11:0] OFF_XRUN    = 12'h060;
	localparam logic [11:0] OFF_TBASE_L = 12'h070;
	localparam logic [11:0] OFF_TBASE_H = 12'h074;
	localparam logic [11:0] OFF_TDB     = 12'h078;
	localparam logic [11:0] OFF_TRUN    = 12'h080;
	localparam logic [11:0] OFF_LCMD    = 12'h090;
	localparam logic [11:0] OFF_LARG0   = 12'h094;
	localparam logic [11:0] OFF_LARG1   = 12'h098;
	localparam logic [11:0] OFF_LARG2   = 12'h09C;
	localparam logic [11:0] OFF_VCFG0   = 12'h0DC;
	localparam logic [11:0] OFF_VCFG1   = 12'h0E0;
	localparam logic [11:0] OFF_HWVER   = 12'h0E4;
	localparam logic [11:0] OFF_CCAP    = 12'h100;
	localparam logic [11:0] OFF_CCAP0   = 12'h104;

	typedef enum logic [4:0] {
		SEL_NONE,
		SEL_CAP,
		SEL_VER,
		SEL_IS,
		SEL_IE,
		SEL_HS,
		SEL_CTRL,
		SEL_XBASE_L,
		SEL_XBASE_H,
		SEL_XDB,
		SEL_XCLR,
		SEL_XRUN,
		SEL_TBASE_L,
		SEL_TBASE_H,
		SEL_TDB,
		SEL_TRUN,
		SEL_LCMD,
		SEL_LARG0,
		SEL_LARG1,
		SEL_LARG2,
		SEL_VCFG0,
		SEL_VCFG1,
		SEL_HWVER,
		SEL_CCAP,
		SEL_CCAP0
	} reg_sel_t;

endpackage

`default_nettype wire

/* design/shcr_decode.sv */
// ----------------------------------------------------------------------------
// Storage host controller register file: address decoder
// Maps an exact byte offset onto a register select code.
// ----------------------------------------------------------------------------
`default_nettype none

module shcr_decode (
	input  wire logic [11:0]       offset,
	output shcr_pkg::reg_sel_t     sel
);
	import shcr_pkg::*;

	always_comb begin
		unique case (offset)
			OFF_CAP:     sel = SEL_CAP;
			OFF_VER:     sel = SEL_VER;
			OFF_IS:      sel = SEL_IS;
			OFF_IE:      sel = SEL_IE;
			OFF_HS:      sel = SEL_HS;
			OFF_CTRL:    sel = SEL_CTRL;
			OFF_XBASE_L: sel = SEL_XBASE_L;
			OFF_XBASE_H: sel = SEL_XBASE_H;
			OFF_XDB:     sel = SEL_XDB;
			OFF_XCLR:    sel = SEL_XCLR;
			OFF_XRUN:    sel = SEL_XRUN;
			OFF_TBASE_L: sel = SEL_TBASE_L;
			OFF_TBASE_H: sel = SEL_TBASE_H;
			OFF_TDB:     sel = SEL_TDB;
			OFF_TRUN:    sel = SEL_TRUN;
			OFF_LCMD:    sel = SEL_LCMD;
			OFF_LARG0:   sel = SEL_LARG0;
			OFF_LARG1:   sel = SEL_LARG1;
			OFF_LARG2:   sel = SEL_LARG2;
			OFF_VCFG0:   sel = SEL_VCFG0;
			OFF_VCFG1:   sel = SEL_VCFG1;
			OFF_HWVER:   sel = SEL_HWVER;
			OFF_CCAP:    sel = SEL_CCAP;
			OFF_CCAP0:   sel = SEL_CCAP0;
			default:     sel = SEL_NONE;
		endcase
	end

endmodule

`default_nettype wire

/* design/shcr_regfile.sv */
// ----------------------------------------------------------------------------
// Storage host controller register file: register state
// Holds all writable registers, forms read data and the interrupt level
// that follows the access, and commits the update when the request retires.
// ----------------------------------------------------------------------------
`default_nettype none

module shcr_regfile (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 commit,
	input  wire logic                 kind,
	input  wire shcr_pkg::reg_sel_t   sel,
	input  wire logic [31:0]          write_data,
	output logic      [31:0]          read_data,
	output logic                      irq_level
);
	import shcr_pkg::*;

	logic [31:0] int_status_q, int_status_d;
	logic [31:0] int_enable_q, int_enable_d;
	logic [3:0]  host_status_q, host_status_d;
	logic        ctrl_enable_q, ctrl_enable_d;
	logic [31:0] list_bases_q [4];
	logic [31:0] list_bases_d [4];
	logic [1:0]  run_stop_q, run_stop_d;
	logic [31:0] link_cmd_q, link_cmd_d;
	logic [31:0] link_args_q [3];
	logic [31:0] link_args_d [3];
	logic [31:0] vendor_cfg_q [2];
	logic [31:0] vendor_cfg_d [2];
	logic [31:0] rd_val;
	logic [7:0]  opcode;
	logic        is_write;

	assign is_write = (kind == KIND_WRITE);
	assign opcode   = write_data[7:0];

	always_comb begin
		unique case (sel)
			SEL_CAP:     rd_val = CAP_WORD;
			SEL_VER:     rd_val = VER_WORD;
			SEL_IS:      rd_val = int_status_q;
			SEL_IE:      rd_val = int_enable_q;
			SEL_HS:      rd_val = HS_READ_FLAG | {28'd0, host_status_q};
			SEL_CTRL:    rd_val = {31'd0, ctrl_enable_q};
			SEL_XBASE_L: rd_val = list_bases_q[0];
			SEL_XBASE_H: rd_val = list_bases_q[1];
			SEL_XRUN:    rd_val = {31'd0, run_stop_q[0]};
			SEL_TBASE_L: rd_val = list_bases_q[2];
			SEL_TBASE_H: rd_val = list_bases_q[3];
			SEL_TRUN:    rd_val = {31'd0, run_stop_q[1]};
			SEL_LCMD:    rd_val = link_cmd_q;
			SEL_LARG0:   rd_val = link_args_q[0];
			SEL_LARG1:   rd_val = link_args_q[1];
			SEL_LARG2:   rd_val = link_args_q[2];
			SEL_VCFG0:   rd_val = vendor_cfg_q[0];
			SEL_VCFG1:   rd_val = vendor_cfg_q[1];
			SEL_HWVER:   rd_val = HWVER_WORD;
			SEL_CCAP:    rd_val = CCAP_WORD;
			SEL_CCAP0:   rd_val = CCAP0_WORD;
			default:     rd_val = 32'd0;
		endcase
	end

	assign read_data = is_write ? 32'd0 : rd_val;

	always_comb begin
		int_status_d  = int_status_q;
		int_enable_d  = int_enable_q;
		host_status_d = host_status_q;
		ctrl_enable_d = ctrl_enable_q;
		list_bases_d  = list_bases_q;
		run_stop_d    = run_stop_q;
		link_cmd_d    = link_cmd_q;
		link_args_d   = link_args_q;
		vendor_cfg_d  = vendor_cfg_q;
		if (is_write) begin
			unique case (sel)
				SEL_IS:      int_status_d = int_status_q & ~write_data;
				SEL_IE:      int_enable_d = write_data;
				SEL_CTRL: begin
					ctrl_enable_d = write_data[0];
					host_status_d = write_data[0] ?
						(HS_CMD_RDY | HS_XFER_RDY | HS_TASK_RDY) : 4'd0;
				end
				SEL_XBASE_L: list_bases_d[0] = write_data;
				SEL_XBASE_H: list_bases_d[1] = write_data;
				SEL_XDB:     int_status_d = int_status_q | ST_XFER_DONE;
				SEL_XRUN: begin
					run_stop_d[0] = write_data[0];
					if (write_data[0]) begin
						host_status_d = host_status_q | HS_XFER_RDY;
					end
				end
				SEL_TBASE_L: list_bases_d[2] = write_data;
				SEL_TBASE_H: list_bases_d[3] = write_data;
				SEL_TDB: begin
					if (write_data != 32'd0) begin
						int_status_d = int_status_q | ST_TASK_DONE;
					end
				end
				SEL_TRUN: begin
					run_stop_d[1] = write_data[0];
					if (write_data[0]) begin
						host_status_d = host_status_q | HS_TASK_RDY;
					end
				end
				SEL_LCMD: begin
					// The link command completes at once; the result argument
					// reports success and status bits follow the opcode.
					link_cmd_d     = write_data;
					link_args_d[1] = 32'd0;
					int_status_d   = int_status_q | ST_CMD_DONE;
					if (opcode == OP_LINKUP) begin
						host_status_d = host_status_q | HS_PRESENT;
						int_status_d  = int_status_d | ST_LINKUP;
					end
					if (opcode == OP_SET && link_args_q[0][31:16] == PWRMODE_ATTR) begin
						int_status_d = int_status_d | ST_PWR;
					end
					if (opcode == OP_HIB_ENTER) begin
						int_status_d = int_status_d | ST_HIB_ENTER;
					end
					if (opcode == OP_HIB_EXIT) begin
						int_status_d = int_status_d | ST_HIB_EXIT;
					end
				end
				SEL_LARG0:   link_args_d[0] = write_data;
				SEL_LARG1:   link_args_d[1] = write_data;
				SEL_LARG2:   link_args_d[2] = write_data;
				SEL_VCFG0:   vendor_cfg_d[0] = write_data;
				SEL_VCFG1:   vendor_cfg_d[1] = write_data;
				default: ;
			endcase
		end
	end

	// The reported level reflects the state after this access.
	assign irq_level = |(int_status_d & int_enable_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_status_q  <= '0;
			int_enable_q  <= '0;
			host_status_q <= '0;
			ctrl_enable_q <= 1'b0;
			list_bases_q  <= '{default: '0};
			run_stop_q    <= '0;
			link_cmd_q    <= '0;
			link_args_q   <= '{default: '0};
			vendor_cfg_q  <= '{default: '0};
		end else if (commit) begin
			int_status_q  <= int_status_d;
			int_enable_q  <= int_enable_d;
			host_status_q <= host_status_d;
			ctrl_enable_q <= ctrl_enable_d;
			list_bases_q  <= list_bases_d;
			run_stop_q    <= run_stop_d;
			link_cmd_q    <= link_cmd_d;
			link_args_q   <= link_args_d;
			vendor_cfg_q  <= vendor_cfg_d;
		end
	end

endmodule

`default_nettype wire

/* design/storage_host_controller_regs_top.sv */
// ----------------------------------------------------------------------------
// Storage host controller register file: top level
// Registers each bus request, decodes and executes it against the register
// state, and registers the response with its interrupt level.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  request   req_valid / req_ready  req (kind, offset, write_data)
//  response  rsp_valid / rsp_ready  rsp (read_data, irq_level)
//
//  A request is registered in the input stage and moves into the response
//  register when that register is free, which raises rsp_valid; the response
//  is then held until it is taken with rsp_ready.
//  One request is accepted per cycle while responses are taken; a stalled
//  response holds the input stage, and req_ready drops once both are full.
//  Register updates take effect when a request moves into the response
//  register. Reset clears the register state and both valid bits.
//
`default_nettype none

module storage_host_controller_regs_top (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire shcr_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output shcr_pkg::rsp_t       rsp
);
	import shcr_pkg::*;

	req_t        req_s1;
	logic        valid_s1;
	rsp_t        rsp_q;
	logic        rsp_valid_q;
	logic        advance;
	reg_sel_t    sel;
	logic [31:0] rd_data;
	logic        irq;

	// The executing request retires when the response register is free.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	shcr_decode u_decode (
		.offset (req_s1.offset),
		.sel    (sel)
	);

	shcr_regfile u_regfile (
		.clk        (clk),
		.arst_n     (arst_n),
		.commit     (advance),
		.kind       (req_s1.kind),
		.sel        (sel),
		.write_data (req_s1.write_data),
		.read_data  (rd_data),
		.irq_level  (irq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.read_data <= rd_data;
			rsp_q.irq_level <= irq;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
